// ----- rtl/kcl_pkg.sv -----
`default_nettype none
package kcl_pkg;

	localparam int unsigned CODE_LENGTH = 4;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned CODE_W = 32;
	localparam int unsigned CODE_BYTES = CODE_W / CHAR_W;
	localparam int unsigned POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam int unsigned FAIL_W = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SCAN_W = 8;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = CODE_W;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_CODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 1'd1;

	localparam logic [CODE_W-1:0] VALID_CODE_RST = 32'h3132_3334;
	localparam logic [FAIL_W-1:0] MAX_ATTEMPTS_RST = 3'd3;
	localparam logic [FAIL_W-1:0] FAIL_SAT = 3'd7;

	localparam logic CMD_KEY = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DIGIT = 3'd0,
		STAT_GRANTED = 3'd1,
		STAT_RETRY = 3'd2,
		STAT_LOCKOUT = 3'd3,
		STAT_IGNORED = 3'd4,
		STAT_CLEARED = 3'd5
	} status_t;

	typedef struct packed {
		logic known;
		logic [CHAR_W-1:0] ch;
	} key_t;

	function automatic key_t translate(input logic [SCAN_W-1:0] scan);
		key_t k;
		k.known = 1'b1;
		unique case (scan)
			8'd238: k.ch = 8'h31;
			8'd237: k.ch = 8'h34;
			8'd235: k.ch = 8'h37;
			8'd222: k.ch = 8'h32;
			8'd221: k.ch = 8'h35;
			8'd219: k.ch = 8'h38;
			8'd190: k.ch = 8'h33;
			8'd189: k.ch = 8'h36;
			8'd187: k.ch = 8'h39;
			8'd123: k.ch = 8'h41;
			8'd183: k.ch = 8'h23;
			8'd215: k.ch = 8'h30;
			8'd231: k.ch = 8'h2a;
			default: begin
				k.known = 1'b0;
				k.ch = '0;
			end
		endcase
		return k;
	endfunction

	// first entered character sits in the most significant used byte
	function automatic logic [CHAR_W-1:0] expected_char(input logic [CODE_W-1:0] code,
		input int unsigned i);
		int unsigned b;
		b = CODE_LENGTH - 1 - i;
		if (b >= CODE_BYTES) begin
			return '0;
		end
		return code[CHAR_W*b +: CHAR_W];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/kcl_if.sv -----
`default_nettype none
interface kcl_event_if;
	logic valid;
	logic ready;
	logic command;
	logic [kcl_pkg::SCAN_W-1:0] scan_code;

	modport source (output valid, output command, output scan_code, input ready);
	modport sink (input valid, input command, input scan_code, output ready);
endinterface

interface kcl_result_if;
	logic valid;
	logic ready;
	logic [kcl_pkg::STATUS_W-1:0] status;
	logic [kcl_pkg::CHAR_W-1:0] key_char;
	logic key_known;

	modport source (output valid, output status, output key_char, output key_known,
		input ready);
	modport sink (input valid, input status, input key_char, input key_known,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/keypad_code_lock.sv -----
// Keypad code lock. Each press transaction carries a command (key press or clear) and the
// keypad scan byte; every transaction yields exactly one result transaction with a status,
// the translated key character and a known flag. After four characters the entry is
// compared with valid_code (first key in the top byte); after max_attempts failures the
// lock ignores keys until a clear. One transaction per cycle is sustained while the result
// side is ready: a press goes through one input register and one result register, and the
// input keeps accepting while the result register holds an untaken transaction only if the
// input register is empty. Configuration is written through cfg_we, cfg_index and cfg_data
// only while the block is idle; the user must ensure this, the block does not enforce it.
`default_nettype none
module keypad_code_lock (
	input  logic clk,
	input  logic arst_n,
	kcl_event_if.sink press,
	kcl_result_if.source result,
	input  logic cfg_we,
	input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned L = kcl_pkg::CODE_LENGTH;

	logic [kcl_pkg::CODE_W-1:0] valid_code_q;
	logic [kcl_pkg::FAIL_W-1:0] max_attempts_q;

	logic valid_s1;
	logic command_s1;
	logic [kcl_pkg::SCAN_W-1:0] scan_s1;

	logic [kcl_pkg::CHAR_W-1:0] entered_q [L];
	logic [kcl_pkg::CHAR_W-1:0] entered_d [L];
	logic [kcl_pkg::POS_W-1:0] pos_q, pos_d;
	logic [kcl_pkg::FAIL_W-1:0] failed_q, failed_d;
	logic locked_q, locked_d;

	logic out_valid_q;
	kcl_pkg::status_t status_q, status_d;
	logic [kcl_pkg::CHAR_W-1:0] char_q, char_d;
	logic known_q, known_d;

	kcl_pkg::key_t key;
	logic advance;
	logic match;

	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign press.ready = !valid_s1 || advance;

	assign result.valid = out_valid_q;
	assign result.status = status_q;
	assign result.key_char = char_q;
	assign result.key_known = known_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_code_q <= kcl_pkg::VALID_CODE_RST;
			max_attempts_q <= kcl_pkg::MAX_ATTEMPTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kcl_pkg::REG_VALID_CODE: valid_code_q <= cfg_data;
				kcl_pkg::REG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[kcl_pkg::FAIL_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (press.ready) begin
			valid_s1 <= press.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (press.valid && press.ready) begin
			command_s1 <= press.command;
			scan_s1 <= press.scan_code;
		end
	end

	always_comb begin
		key = kcl_pkg::translate(scan_s1);
		entered_d = entered_q;
		pos_d = pos_q;
		failed_d = failed_q;
		locked_d = locked_q;
		status_d = kcl_pkg::STAT_DIGIT;
		char_d = key.ch;
		known_d = key.known;
		match = 1'b1;
		if (command_s1 == kcl_pkg::CMD_CLEAR) begin
			for (int i = 0; i < L; i++) begin
				entered_d[i] = '0;
			end
			pos_d = '0;
			failed_d = '0;
			locked_d = 1'b0;
			status_d = kcl_pkg::STAT_CLEARED;
			char_d = '0;
			known_d = 1'b0;
		end else if (locked_q) begin
			status_d = kcl_pkg::STAT_IGNORED;
		end else begin
			for (int i = 0; i < L; i++) begin
				if (pos_q == kcl_pkg::POS_W'(i)) begin
					entered_d[i] = key.ch;
				end
			end
			for (int i = 0; i < L; i++) begin
				if (entered_d[i] != kcl_pkg::expected_char(valid_code_q, i)) begin
					match = 1'b0;
				end
			end
			if (pos_q != kcl_pkg::POS_W'(L - 1)) begin
				pos_d = pos_q + kcl_pkg::POS_W'(1);
			end else begin
				pos_d = '0;
				if (match) begin
					failed_d = '0;
					status_d = kcl_pkg::STAT_GRANTED;
				end else begin
					if (failed_q != kcl_pkg::FAIL_SAT) begin
						failed_d = failed_q + kcl_pkg::FAIL_W'(1);
					end
					if (failed_d >= max_attempts_q) begin
						locked_d = 1'b1;
						status_d = kcl_pkg::STAT_LOCKOUT;
					end else begin
						status_d = kcl_pkg::STAT_RETRY;
					end
				end
			end
		end
	end

	// lock state advances with each transaction that moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) begin
				entered_q[i] <= '0;
			end
			pos_q <= '0;
			failed_q <= '0;
			locked_q <= 1'b0;
		end else if (advance) begin
			entered_q <= entered_d;
			pos_q <= pos_d;
			failed_q <= failed_d;
			locked_q <= locked_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			char_q <= char_d;
			known_q <= known_d;
		end
	end

endmodule
`default_nettype wire

// ----- dv/tb_keypad_code_lock.sv -----
`timescale 1ns / 1ps
module tb_keypad_code_lock;
	import kcl_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic command;
		logic [SCAN_W-1:0] scan;
	} press_t;

	typedef struct {
		status_t status;
		logic [CHAR_W-1:0] ch;
		logic known;
	} lock_outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kcl_event_if press_bus ();
	kcl_result_if result_bus ();

	keypad_code_lock dut (
		.clk(clk),
		.arst_n(arst_n),
		.press(press_bus),
		.result(result_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	press_t press_queue[$];
	lock_outcome_t lock_outcomes[$];
	bit steady_flow;
	int errors;
	int n_results;
	int n_settings;
	int stall_cycles;
	int status_seen [6];

	// lock state as the block should hold it
	logic [CHAR_W-1:0] entered [CODE_LENGTH];
	int unsigned entry_pos;
	logic [FAIL_W-1:0] fail_cnt;
	logic locked;
	logic [CODE_W-1:0] code_reg;
	logic [FAIL_W-1:0] max_att_reg;

	// {known, ascii}
	function automatic logic [8:0] keypad_lookup(input logic [SCAN_W-1:0] scan);
		case (scan)
			8'd238: return {1'b1, 8'h31};
			8'd237: return {1'b1, 8'h34};
			8'd235: return {1'b1, 8'h37};
			8'd222: return {1'b1, 8'h32};
			8'd221: return {1'b1, 8'h35};
			8'd219: return {1'b1, 8'h38};
			8'd190: return {1'b1, 8'h33};
			8'd189: return {1'b1, 8'h36};
			8'd187: return {1'b1, 8'h39};
			8'd123: return {1'b1, 8'h41};
			8'd183: return {1'b1, 8'h23};
			8'd215: return {1'b1, 8'h30};
			8'd231: return {1'b1, 8'h2a};
			default: return 9'd0;
		endcase
	endfunction

	function automatic logic [SCAN_W-1:0] keypad_scan(input int idx);
		case (idx)
			0: return 8'd238;
			1: return 8'd237;
			2: return 8'd235;
			3: return 8'd222;
			4: return 8'd221;
			5: return 8'd219;
			6: return 8'd190;
			7: return 8'd189;
			8: return 8'd187;
			9: return 8'd123;
			10: return 8'd183;
			11: return 8'd215;
			default: return 8'd231;
		endcase
	endfunction

	function automatic lock_outcome_t lock_step(input logic cmd, input logic [SCAN_W-1:0] scan);
		lock_outcome_t o;
		logic [8:0] k;
		logic match;
		o.status = STAT_DIGIT;
		o.ch = '0;
		o.known = 1'b0;
		if (cmd == CMD_CLEAR) begin
			locked = 1'b0;
			fail_cnt = '0;
			entry_pos = 0;
			foreach (entered[i]) entered[i] = '0;
			o.status = STAT_CLEARED;
			return o;
		end
		k = keypad_lookup(scan);
		o.ch = k[7:0];
		o.known = k[8];
		if (locked) begin
			o.status = STAT_IGNORED;
		end else begin
			entered[entry_pos] = o.ch;
			entry_pos++;
			if (entry_pos >= CODE_LENGTH) begin
				entry_pos = 0;
				match = 1'b1;
				for (int i = 0; i < CODE_LENGTH; i++) begin
					if (entered[i] != code_reg[CHAR_W*(CODE_LENGTH-1-i) +: CHAR_W])
						match = 1'b0;
				end
				if (match) begin
					fail_cnt = '0;
					o.status = STAT_GRANTED;
				end else begin
					if (fail_cnt != FAIL_SAT)
						fail_cnt++;
					if (fail_cnt >= max_att_reg) begin
						locked = 1'b1;
						o.status = STAT_LOCKOUT;
					end else begin
						o.status = STAT_RETRY;
					end
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic logic [CODE_W-1:0] random_key_code();
		logic [CODE_W-1:0] c;
		logic [8:0] k;
		c = '0;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			k = keypad_lookup(keypad_scan($urandom_range(12)));
			c = {c[CODE_W-CHAR_W-1:0], k[7:0]};
		end
		return c;
	endfunction

	// zero is typed with an unknown scan byte, other non-key bytes with a random one
	function automatic logic [SCAN_W-1:0] scan_for_char(input logic [CHAR_W-1:0] ch);
		logic [8:0] k;
		logic [SCAN_W-1:0] s;
		if (ch == 8'h00) begin
			do begin
				s = SCAN_W'($urandom_range(255));
				k = keypad_lookup(s);
			end while (k[8]);
			return s;
		end
		for (int i = 0; i < 13; i++) begin
			k = keypad_lookup(keypad_scan(i));
			if (k[7:0] == ch)
				return keypad_scan(i);
		end
		return SCAN_W'($urandom_range(255));
	endfunction

	task automatic push_press(input logic cmd, input logic [SCAN_W-1:0] scan);
		press_t p;
		p.command = cmd;
		p.scan = scan;
		press_queue.push_back(p);
	endtask

	task automatic enter_code(input logic [CODE_W-1:0] code);
		for (int i = 0; i < CODE_LENGTH; i++)
			push_press(CMD_KEY, scan_for_char(code[CHAR_W*(CODE_LENGTH-1-i) +: CHAR_W]));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_lock_config(input logic [CODE_W-1:0] code, input logic [FAIL_W-1:0] max_att);
		write_reg(REG_VALID_CODE, code);
		write_reg(REG_MAX_ATTEMPTS, CFG_DATA_W'(max_att));
		code_reg = code;
		max_att_reg = max_att;
		n_settings++;
	endtask

	task automatic wait_drained();
		while (press_queue.size() != 0 || press_bus.valid || lock_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly well-formed code entries, plus wrong codes, stray presses and clears
	task automatic fill_phase(input int n);
		int pushed;
		int pick;
		int burst;
		pushed = 0;
		while (pushed < n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				enter_code(code_reg);
				pushed += CODE_LENGTH;
			end else if (pick < 78) begin
				enter_code(random_key_code());
				pushed += CODE_LENGTH;
			end else if (pick < 90) begin
				burst = $urandom_range(1, 3);
				repeat (burst) push_press(CMD_KEY, SCAN_W'($urandom_range(255)));
				pushed += burst;
			end else begin
				push_press(CMD_CLEAR, SCAN_W'($urandom_range(255)));
				pushed++;
			end
		end
	endtask

	task automatic run_phase(input logic [CODE_W-1:0] code, input logic [FAIL_W-1:0] max_att,
		input int n, input bit steady);
		set_lock_config(code, max_att);
		steady_flow = steady;
		@(negedge clk);
		fill_phase(n);
		wait_drained();
	endtask

	always @(posedge clk) begin
		press_t nxt;
		if (!arst_n) begin
			press_bus.valid <= 1'b0;
			press_bus.command <= CMD_KEY;
			press_bus.scan_code <= '0;
		end else if (!press_bus.valid || press_bus.ready) begin
			if (press_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 8)) begin
				nxt = press_queue.pop_front();
				press_bus.valid <= 1'b1;
				press_bus.command <= nxt.command;
				press_bus.scan_code <= nxt.scan;
			end else begin
				press_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			result_bus.ready <= 1'b0;
		else
			result_bus.ready <= steady_flow || ($urandom_range(99) >= 8);
	end

	always @(posedge clk) begin
		lock_outcome_t exp_r;
		if (arst_n) begin
			if (press_bus.valid && press_bus.ready)
				lock_outcomes.push_back(lock_step(press_bus.command, press_bus.scan_code));
			if (result_bus.valid && result_bus.ready) begin
				n_results++;
				if (lock_outcomes.size() == 0) begin
					report_mismatch($sformatf("unexpected result transaction status=%0d",
						result_bus.status));
				end else begin
					exp_r = lock_outcomes.pop_front();
					status_seen[exp_r.status]++;
					if (result_bus.status !== exp_r.status)
						report_mismatch($sformatf("status got %0d expected %s",
							result_bus.status, exp_r.status.name()));
					if (result_bus.key_char !== exp_r.ch)
						report_mismatch($sformatf("key_char got %02h expected %02h",
							result_bus.key_char, exp_r.ch));
					if (result_bus.key_known !== exp_r.known)
						report_mismatch($sformatf("key_known got %0b expected %0b",
							result_bus.key_known, exp_r.known));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((press_bus.valid && press_bus.ready) || (result_bus.valid && result_bus.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		press_bus.valid = 1'b0;
		press_bus.command = CMD_KEY;
		press_bus.scan_code = '0;
		result_bus.ready = 1'b0;
		steady_flow = 1'b0;
		errors = 0;
		n_results = 0;
		n_settings = 1;
		stall_cycles = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (entered[i]) entered[i] = '0;
		entry_pos = 0;
		fail_cnt = '0;
		locked = 1'b0;
		code_reg = VALID_CODE_RST;
		max_att_reg = MAX_ATTEMPTS_RST;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: clear while open, grant, unknown keys, all keys but 2 and 3, lockout
		push_press(CMD_CLEAR, 8'hff);
		enter_code(VALID_CODE_RST);
		push_press(CMD_KEY, 8'h00);
		push_press(CMD_KEY, 8'hff);
		push_press(CMD_KEY, 8'd221);
		push_press(CMD_KEY, 8'd189);
		push_press(CMD_KEY, 8'd235);
		push_press(CMD_KEY, 8'd219);
		push_press(CMD_KEY, 8'd187);
		push_press(CMD_KEY, 8'd123);
		push_press(CMD_KEY, 8'd183);
		push_press(CMD_KEY, 8'd215);
		push_press(CMD_KEY, 8'd231);
		push_press(CMD_KEY, 8'd237);
		push_press(CMD_KEY, 8'd238);
		push_press(CMD_KEY, 8'h55);
		push_press(CMD_CLEAR, 8'h00);
		enter_code(VALID_CODE_RST);
		wait_drained();

		run_phase(random_key_code(), 3'd1, 220, 1'b0);
		run_phase(random_key_code(), 3'd7, 220, 1'b1);
		run_phase(32'h0000_0000, 3'd2, 150, 1'b0);
		run_phase(32'hffff_ffff, 3'd4, 120, 1'b0);
		run_phase($urandom, 3'd0, 120, 1'b0);
		run_phase(random_key_code(), 3'd5, 300, 1'b0);
		run_phase(random_key_code(), 3'd3, 250, 1'b0);

		repeat (8) @(negedge clk);
		$display("%0d result transactions checked across %0d register settings", n_results,
			n_settings);
		$display("granted %0d, retry %0d, lockout %0d, ignored %0d, cleared %0d, digits %0d",
			status_seen[STAT_GRANTED], status_seen[STAT_RETRY], status_seen[STAT_LOCKOUT],
			status_seen[STAT_IGNORED], status_seen[STAT_CLEARED], status_seen[STAT_DIGIT]);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/kcl_pkg.sv
rtl/kcl_if.sv
rtl/keypad_code_lock.sv
dv/tb_keypad_code_lock.sv
